// ===== rtl/gfc_pkg.sv =====
`timescale 1ns / 1ps

package gfc_pkg;

   // register indexes on the csr channel
   localparam logic [2:0] CSR_CANVAS_WIDTH      = 3'd0;
   localparam logic [2:0] CSR_RECT_LEFT         = 3'd1;
   localparam logic [2:0] CSR_RECT_TOP          = 3'd2;
   localparam logic [2:0] CSR_RECT_WIDTH        = 3'd3;
   localparam logic [2:0] CSR_RECT_HEIGHT       = 3'd4;
   localparam logic [2:0] CSR_TRANSPARENT_INDEX = 3'd5;
   localparam logic [2:0] CSR_FILL_INDEX        = 3'd6;
   localparam logic [2:0] CSR_KEEP_PREVIOUS     = 3'd7;

   localparam int DEFAULT_MAX_PIXELS = 65536;

   localparam int COORD_W = 16;
   localparam int INDEX_W = 8;
   localparam int CSR_DATA_W = 16;

   // canvas position of one pixel
   typedef struct packed {
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
   } pos_type;

   // step request from the front end to the position tracker
   typedef struct packed {
      logic step;   // a pixel word is accepted this cycle
      logic start;  // that word opens a frame
   } track_ctrl_type;

endpackage

// ===== rtl/gfc_pos_track.sv =====
`timescale 1ns / 1ps

module gfc_pos_track #(
   parameter int MAX_PIXELS = gfc_pkg::DEFAULT_MAX_PIXELS,
   parameter int AW = $clog2(MAX_PIXELS)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  gfc_pkg::track_ctrl_type     ctrl,
   input  logic [gfc_pkg::COORD_W-1:0] canvas_width,
   input  logic                        width_load,
   output gfc_pkg::pos_type            cur_pos,
   output logic [AW-1:0]               cur_addr,
   output logic                        busy
);
   import gfc_pkg::*;

   localparam logic [AW:0] MOD = (AW+1)'(MAX_PIXELS);

   typedef enum logic [1:0] {
      TRK_IDLE,
      TRK_REDUCE,
      TRK_MULT,
      TRK_FINISH
   } trk_state_type;

   // (a + b) mod MAX_PIXELS for a, b below MAX_PIXELS
   function automatic logic [AW-1:0] mod_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
      logic [AW:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= MOD) s = s - MOD;
      return s[AW-1:0];
   endfunction

   // (2a + b) mod MAX_PIXELS for a below MAX_PIXELS
   function automatic logic [AW-1:0] mod_dbl(input logic [AW-1:0] a, input logic b);
      logic [AW:0] s;
      s = {a, b};
      if (s >= MOD) s = s - MOD;
      return s[AW-1:0];
   endfunction

   trk_state_type    state_ff;
   logic [3:0]       cnt_ff;
   logic [COORD_W-1:0] row_ff, row_in;
   logic [COORD_W-1:0] col_ff, col_in;
   logic [AW-1:0]    rowbase_ff, rowbase_in;   // row * width mod MAX_PIXELS
   logic [AW-1:0]    addr_ff, addr_in;         // rowbase + col mod MAX_PIXELS
   logic [AW-1:0]    wm_ff;                    // width mod MAX_PIXELS

   logic [3:0]       bit_sel;
   logic [COORD_W:0] col_next;
   logic             wrap;
   logic [AW:0]      addr_inc;

   assign bit_sel = ~cnt_ff;
   assign busy    = (state_ff != TRK_IDLE);

   // position of the pixel taken now
   always_comb begin
      cur_pos.row = ctrl.start ? '0 : row_ff;
      cur_pos.col = ctrl.start ? '0 : col_ff;
      cur_addr    = ctrl.start ? '0 : addr_ff;
   end

   always_comb begin
      col_next = {1'b0, cur_pos.col} + 1'b1;
      wrap     = (col_next >= {1'b0, canvas_width});
      addr_inc = {1'b0, cur_addr} + 1'b1;
      if (wrap) begin
         col_in = '0;
         row_in = cur_pos.row + 1'b1;
         // row wraps to zero: its base returns to zero too
         rowbase_in = (row_in == '0) ? '0 :
                      mod_add(ctrl.start ? '0 : rowbase_ff, wm_ff);
         addr_in = rowbase_in;
      end else begin
         col_in     = col_next[COORD_W-1:0];
         row_in     = cur_pos.row;
         rowbase_in = ctrl.start ? '0 : rowbase_ff;
         addr_in    = (addr_inc == MOD) ? '0 : addr_inc[AW-1:0];
      end
   end

   // a width write rebuilds the bases from row and column, one bit a cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= TRK_IDLE;
         cnt_ff     <= '0;
         row_ff     <= '0;
         col_ff     <= '0;
         rowbase_ff <= '0;
         addr_ff    <= '0;
         wm_ff      <= AW'(1);
      end else if (width_load) begin
         state_ff   <= TRK_REDUCE;
         cnt_ff     <= '0;
         rowbase_ff <= '0;
         addr_ff    <= '0;
         wm_ff      <= '0;
      end else begin
         case (state_ff)
            TRK_IDLE: begin
               if (ctrl.step) begin
                  row_ff     <= row_in;
                  col_ff     <= col_in;
                  rowbase_ff <= rowbase_in;
                  addr_ff    <= addr_in;
               end
            end
            TRK_REDUCE: begin
               // addr_ff gathers col mod MAX_PIXELS here
               wm_ff   <= mod_dbl(wm_ff, canvas_width[bit_sel]);
               addr_ff <= mod_dbl(addr_ff, col_ff[bit_sel]);
               cnt_ff  <= cnt_ff + 1'b1;
               if (cnt_ff == 4'hF) state_ff <= TRK_MULT;
            end
            TRK_MULT: begin
               rowbase_ff <= mod_add(mod_dbl(rowbase_ff, 1'b0),
                                     row_ff[bit_sel] ? wm_ff : '0);
               cnt_ff     <= cnt_ff + 1'b1;
               if (cnt_ff == 4'hF) state_ff <= TRK_FINISH;
            end
            TRK_FINISH: begin
               addr_ff  <= mod_add(rowbase_ff, addr_ff);
               state_ff <= TRK_IDLE;
            end
            default: state_ff <= TRK_IDLE;
         endcase
      end
   end

endmodule

// ===== rtl/gif_frame_compositor.sv =====
`timescale 1ns / 1ps

// channel  dir  handshake              payload
// req      in   req_tvalid/req_tready  tdata: source_index; tuser: frame_start
// rsp      out  rsp_tvalid/rsp_tready  tdata: pixel_index;  tuser: inside_rect
// csr      in   csr_valid/csr_ready    csr_index, csr_data
//
// One pixel per clock: input register (frame store read) then result register.
// The frame store is one write and one read port per cycle, with the word just
// composed forwarded to a following word at the same address. A canvas_width
// write rebuilds the store address (reduce, multiply, finish), req_tready low.
// Reset is synchronous; rsp stalls hold the result and back up into req_tready.

module gif_frame_compositor #(
   parameter int MAX_PIXELS = gfc_pkg::DEFAULT_MAX_PIXELS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [7:0]                     req_tdata,   // [7:0] source_index
   input  logic                           req_tuser,   // [0] frame_start
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [7:0]                     rsp_tdata,   // [7:0] pixel_index
   output logic                           rsp_tuser,   // [0] inside_rect
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [2:0]                     csr_index,
   input  logic [gfc_pkg::CSR_DATA_W-1:0] csr_data
);
   import gfc_pkg::*;

   localparam int AW = $clog2(MAX_PIXELS);

   // configuration
   logic [COORD_W-1:0] canvas_width_ff, rect_left_ff, rect_top_ff;
   logic [COORD_W-1:0] rect_width_ff, rect_height_ff;
   logic [8:0]         transparent_ff;
   logic [INDEX_W-1:0] fill_ff;
   logic               keep_ff;

   logic csr_write;
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid & csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         canvas_width_ff <= 16'd1;
         rect_left_ff    <= '0;
         rect_top_ff     <= '0;
         rect_width_ff   <= '0;
         rect_height_ff  <= '0;
         transparent_ff  <= 9'h1FF;
         fill_ff         <= '0;
         keep_ff         <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_CANVAS_WIDTH:      canvas_width_ff <= csr_data;
            CSR_RECT_LEFT:         rect_left_ff    <= csr_data;
            CSR_RECT_TOP:          rect_top_ff     <= csr_data;
            CSR_RECT_WIDTH:        rect_width_ff   <= csr_data;
            CSR_RECT_HEIGHT:       rect_height_ff  <= csr_data;
            CSR_TRANSPARENT_INDEX: transparent_ff  <= csr_data[8:0];
            CSR_FILL_INDEX:        fill_ff         <= csr_data[INDEX_W-1:0];
            CSR_KEEP_PREVIOUS:     keep_ff         <= csr_data[0];
            default: ;
         endcase
      end
   end

   // handshake
   logic s1_valid_ff, out_valid_ff;
   logic s1_adv, req_accept, trk_busy;

   assign s1_adv     = s1_valid_ff & (~out_valid_ff | rsp_tready);
   assign req_tready = ~trk_busy & (~s1_valid_ff | s1_adv);
   assign req_accept = req_tvalid & req_tready;

   track_ctrl_type   trk_ctrl;
   pos_type          cur_pos;
   logic [AW-1:0]    cur_addr;

   assign trk_ctrl.step  = req_accept;
   assign trk_ctrl.start = req_tuser;

   gfc_pos_track #(
      .MAX_PIXELS (MAX_PIXELS),
      .AW         (AW)
   ) u_track (
      .clock        (clock),
      .reset        (reset),
      .ctrl         (trk_ctrl),
      .canvas_width (canvas_width_ff),
      .width_load   (csr_write && csr_index == CSR_CANVAS_WIDTH),
      .cur_pos      (cur_pos),
      .cur_addr     (cur_addr),
      .busy         (trk_busy)
   );

   // input register and frame store
   logic [INDEX_W-1:0] mem_ff [MAX_PIXELS];
   logic [INDEX_W-1:0] s1_src_ff, rd_ff, fwd_val_ff;
   logic               fwd_ff;
   pos_type            s1_pos_ff;
   logic [AW-1:0]      s1_addr_ff;
   logic [INDEX_W-1:0] result;
   logic               in_rect;

   always_ff @(posedge clock) begin
      if (s1_adv) mem_ff[s1_addr_ff] <= result;
      if (req_accept) rd_ff <= mem_ff[cur_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_src_ff  <= req_tdata;
         s1_pos_ff  <= cur_pos;
         s1_addr_ff <= cur_addr;
         // the word leaving now writes the address being read: forward it
         fwd_ff     <= s1_adv && (s1_addr_ff == cur_addr);
         fwd_val_ff <= result;
      end
   end

   // compose
   logic [INDEX_W-1:0] previous;
   logic [COORD_W:0]   row_end, col_end;
   logic               transparent_hit;

   always_comb begin
      previous = fwd_ff ? fwd_val_ff : rd_ff;
      row_end  = {1'b0, rect_top_ff} + {1'b0, rect_height_ff};
      col_end  = {1'b0, rect_left_ff} + {1'b0, rect_width_ff};
      in_rect  = (s1_pos_ff.row >= rect_top_ff) && ({1'b0, s1_pos_ff.row} < row_end) &&
                 (s1_pos_ff.col >= rect_left_ff) && ({1'b0, s1_pos_ff.col} < col_end);
      // sign bit set means no transparent index
      transparent_hit = ~transparent_ff[8] && (s1_src_ff == transparent_ff[7:0]);
      if (!in_rect) result = keep_ff ? previous : fill_ff;
      else if (keep_ff && transparent_hit) result = previous;
      else result = s1_src_ff;
   end

   // result register
   logic [INDEX_W-1:0] out_pix_ff;
   logic               out_inside_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         out_pix_ff    <= result;
         out_inside_ff <= in_rect;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_pix_ff;
   assign rsp_tuser  = out_inside_ff;

endmodule

// ===== tb/gfc_compose_checker.sv =====
`timescale 1ns / 1ps

module gfc_compose_checker
   import gfc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [7:0] source_index
   input  logic                  req_tuser,   // [0] frame_start
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [7:0]            rsp_tdata,   // [7:0] pixel_index
   input  logic                  rsp_tuser,   // [0] inside_rect
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [2:0]            csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output int                    fail_count,
   output int                    pending_words
);

   localparam int STORE_DEPTH = DEFAULT_MAX_PIXELS;

   typedef struct packed {
      logic [INDEX_W-1:0] pixel;
      logic               in_rect;
   } composed_type;

   logic [COORD_W-1:0] canvas_width;
   logic [COORD_W-1:0] rect_left;
   logic [COORD_W-1:0] rect_top;
   logic [COORD_W-1:0] rect_width;
   logic [COORD_W-1:0] rect_height;
   logic [8:0]         transparent_index;
   logic [INDEX_W-1:0] fill_index;
   logic               keep_previous;
   logic [COORD_W-1:0] row_count;
   logic [COORD_W-1:0] col_count;
   logic [INDEX_W-1:0] canvas_store [0:STORE_DEPTH-1];
   composed_type       expected_pixels [$];
   int                 word_seq;

   initial begin
      for (int i = 0; i < STORE_DEPTH; i++) canvas_store[i] = '0;
      fail_count = 0;
      pending_words = 0;
      word_seq = 0;
   end

   // compose one canvas pixel and advance the raster position
   function automatic composed_type compose_pixel(input logic [INDEX_W-1:0] src,
                                                  input logic start);
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
      logic [16:0]        next_col;
      logic [31:0]        linear;
      int                 addr;
      logic               hit;
      composed_type       word;
      row = start ? '0 : row_count;
      col = start ? '0 : col_count;
      // bounds use 17-bit sums so a rectangle past the edge does not wrap
      word.in_rect = row >= rect_top && 17'(row) < 17'(rect_top) + 17'(rect_height) &&
                     col >= rect_left && 17'(col) < 17'(rect_left) + 17'(rect_width);
      linear = 32'(row) * 32'(canvas_width) + 32'(col);
      addr = int'(linear % STORE_DEPTH);
      hit = !transparent_index[8] && src == transparent_index[7:0];
      if (!word.in_rect)
         word.pixel = keep_previous ? canvas_store[addr] : fill_index;
      else if (keep_previous && hit)
         word.pixel = canvas_store[addr];
      else
         word.pixel = src;
      canvas_store[addr] = word.pixel;
      next_col = 17'(col) + 17'd1;
      if (next_col >= 17'(canvas_width)) begin
         col_count = '0;
         row_count = row + 1'b1;
      end else begin
         col_count = next_col[15:0];
         row_count = row;
      end
      return word;
   endfunction

   always @(posedge clock) begin : monitor
      composed_type want;
      if (reset) begin
         canvas_width = 16'd1;
         rect_left = '0;
         rect_top = '0;
         rect_width = '0;
         rect_height = '0;
         transparent_index = 9'h1FF;
         fill_index = '0;
         keep_previous = 1'b0;
         row_count = '0;
         col_count = '0;
         expected_pixels.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_CANVAS_WIDTH:      canvas_width = csr_data;
               CSR_RECT_LEFT:         rect_left = csr_data;
               CSR_RECT_TOP:          rect_top = csr_data;
               CSR_RECT_WIDTH:        rect_width = csr_data;
               CSR_RECT_HEIGHT:       rect_height = csr_data;
               CSR_TRANSPARENT_INDEX: transparent_index = csr_data[8:0];
               CSR_FILL_INDEX:        fill_index = csr_data[7:0];
               CSR_KEEP_PREVIOUS:     keep_previous = csr_data[0];
               default: ;
            endcase
         end
         // a result never comes out in the cycle its pixel goes in: pop before push
         if (rsp_tvalid && rsp_tready) begin
            if (expected_pixels.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: pixel word %0d: got index %h in_rect %b with none expected",
                           $time, word_seq, rsp_tdata, rsp_tuser);
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_tdata !== want.pixel || rsp_tuser !== want.in_rect) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("%0t: pixel word %0d: expected index %h in_rect %b, got %h %b",
                              $time, word_seq, want.pixel, want.in_rect, rsp_tdata, rsp_tuser);
               end
            end
            word_seq++;
         end
         if (req_tvalid && req_tready)
            expected_pixels.push_back(compose_pixel(req_tdata, req_tuser));
      end
      pending_words = expected_pixels.size();
   end

endmodule

// ===== tb/tb_gif_frame_compositor.sv =====
`timescale 1ns / 1ps

module tb_gif_frame_compositor;
   import gfc_pkg::*;

   localparam int CYCLE_LIMIT = 200_000;
   localparam int RANDOM_WORDS = 450;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [7:0]            req_tdata;   // [7:0] source_index
   logic                  req_tuser;   // [0] frame_start
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [7:0]            rsp_tdata;   // [7:0] pixel_index
   logic                  rsp_tuser;   // [0] inside_rect
   logic                  csr_valid;
   logic                  csr_ready;
   logic [2:0]            csr_index;
   logic [CSR_DATA_W-1:0] csr_data;
   int                    fail_count;
   int                    pending_words;

   // what the stimulus knows of the canvas, so keep-previous only reads written entries
   logic [15:0] cur_width;
   logic        cur_keep;
   logic [8:0]  cur_transparent;
   int          frame_pos;
   int          written_span;
   logic        restart_due;
   logic        calm;
   int          word_count;
   int          setting_count;
   int          cycle_count;

   gif_frame_compositor dut (.*);

   gfc_compose_checker compose_check (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(negedge clock) rsp_tready <= calm || $urandom_range(99) >= 12;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_gif_frame_compositor: done, errors");
         $finish;
      end
   end

   task automatic write_reg(input logic [2:0] index, input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // drain the pipe, then load a full register set
   task automatic apply_setting(input logic [15:0] width, input logic [15:0] left,
                                input logic [15:0] top, input logic [15:0] rwidth,
                                input logic [15:0] rheight, input logic [8:0] transparent,
                                input logic [7:0] fill, input logic keep);
      req_tvalid <= 1'b0;
      while (pending_words != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      write_reg(CSR_CANVAS_WIDTH, width);
      write_reg(CSR_RECT_LEFT, left);
      write_reg(CSR_RECT_TOP, top);
      write_reg(CSR_RECT_WIDTH, rwidth);
      write_reg(CSR_RECT_HEIGHT, rheight);
      write_reg(CSR_TRANSPARENT_INDEX, {{7{transparent[8]}}, transparent});
      write_reg(CSR_FILL_INDEX, 16'(fill));
      write_reg(CSR_KEEP_PREVIOUS, 16'(keep));
      cur_width = width;
      cur_keep = keep;
      cur_transparent = transparent;
      restart_due = 1'b1;
      setting_count++;
   endtask

   task automatic send_pixel(input logic [7:0] src, input logic start);
      logic opened;
      int   addr;
      opened = start || restart_due;
      // force a frame start rather than read an entry never written
      if (!opened && cur_keep && cur_width != 0 && frame_pos % DEFAULT_MAX_PIXELS >= written_span)
         opened = 1'b1;
      if (opened) frame_pos = 0;
      addr = (cur_width == 0) ? 0 : frame_pos % DEFAULT_MAX_PIXELS;
      while (!calm && $urandom_range(99) < 12) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= src;
      req_tuser <= opened;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (addr >= written_span) written_span = addr + 1;
      frame_pos++;
      restart_due = 1'b0;
      word_count++;
      @(negedge clock);
   endtask

   task automatic send_frame(input int words, input logic opened, input logic noisy);
      logic [7:0] src;
      for (int k = 0; k < words; k++) begin
         if (!cur_transparent[8] && $urandom_range(3) == 0) src = cur_transparent[7:0];
         else src = 8'($urandom_range(255));
         send_pixel(src, (k == 0 && opened) || (noisy && $urandom_range(19) == 0));
      end
   endtask

   initial begin
      logic [15:0] w, l, t, rw, rh;
      logic [8:0]  tr;
      logic [7:0]  fi;
      logic [7:0]  src;
      logic        kp;
      int          phase, variant, rows, words, frames;
      clock = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 1'b0;
      rsp_tready = 1'b0;
      csr_valid = 1'b0;
      csr_index = CSR_CANVAS_WIDTH;
      csr_data = '0;
      calm = 1'b0;
      cur_width = 16'd1;
      cur_keep = 1'b0;
      cur_transparent = 9'h1FF;
      frame_pos = 0;
      written_span = 0;
      restart_due = 1'b0;
      word_count = 0;
      setting_count = 0;
      cycle_count = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // 4-wide canvas, 2x2 rectangle at column 1: first frame, nothing kept
      apply_setting(16'd4, 16'd1, 16'd0, 16'd2, 16'd2, 9'd5, 8'hFF, 1'b0);
      for (int k = 0; k < 12; k++) begin
         case (k)
            1: src = 8'hFF;
            2: src = 8'd5;
            5: src = 8'h00;
            default: src = 8'($urandom_range(255));
         endcase
         send_pixel(src, k == 0);
      end
      // keep previous: transparent hits and outside pixels hold, restart mid-frame
      apply_setting(16'd4, 16'd1, 16'd0, 16'd2, 16'd2, 9'd5, 8'h00, 1'b1);
      for (int k = 0; k < 9; k++)
         send_pixel((k == 6) ? 8'h80 : 8'd5, k == 0 || k == 7);
      // no transparency: index 5 goes through even with keep previous
      apply_setting(16'd4, 16'd0, 16'd0, 16'd4, 16'd1, 9'h1FF, 8'h00, 1'b1);
      for (int k = 0; k < 4; k++) send_pixel(8'd5, k == 0);

      phase = 0;
      while (word_count < RANDOM_WORDS) begin
         variant = (phase < 6) ? phase : $urandom_range(9);
         case (variant)
            0: w = 16'd0;
            1: w = 16'hFFFF;
            default: w = 16'($urandom_range(12, 1));
         endcase
         rows = $urandom_range(5, 1);
         words = (w == 16'd0 || w == 16'hFFFF) ? $urandom_range(40, 3) : rows * w;
         l = 16'($urandom_range(w));
         rw = 16'($urandom_range(w));
         t = 16'($urandom_range(rows));
         rh = 16'($urandom_range(rows));
         case (variant)
            2: begin
               // bound sums carry out of 16 bits
               l = 16'd1;
               rw = 16'hFFFF;
               t = 16'd2;
               rh = 16'hFFFF;
            end
            3: rw = 16'd0;
            4: begin
               l = 16'hFFFF;
               t = 16'hFFFF;
               rw = 16'hFFFF;
               rh = 16'hFFFF;
            end
            default: ;
         endcase
         case ($urandom_range(4))
            0: tr = {1'b1, 8'($urandom_range(255))};
            1: tr = 9'h000;
            2: tr = 9'h0FF;
            default: tr = 9'($urandom_range(255));
         endcase
         case ($urandom_range(3))
            0: fi = 8'h00;
            1: fi = 8'hFF;
            default: fi = 8'($urandom_range(255));
         endcase
         kp = written_span >= words && $urandom_range(2) != 0;
         apply_setting(w, l, t, rw, rh, tr, fi, kp);
         calm = (phase == 3);
         frames = $urandom_range(3, 2);
         for (int f = 0; f < frames; f++)
            send_frame(words, f == 0 || $urandom_range(3) != 0, 1'b1);
         calm = 1'b0;
         phase++;
      end

      // width change mid-frame: the address is rebuilt from the held row and column,
      // and row 3 of a 0x6000-wide canvas lands past the end of the store
      apply_setting(16'd3, 16'd0, 16'd2, 16'd2, 16'd4, 9'h1FF, 8'h3C, 1'b0);
      send_frame(10, 1'b1, 1'b0);
      req_tvalid <= 1'b0;
      while (pending_words != 0) @(negedge clock);
      write_reg(CSR_CANVAS_WIDTH, 16'h6000);
      cur_width = 16'h6000;
      setting_count++;
      send_frame(6, 1'b0, 1'b0);

      req_tvalid <= 1'b0;
      while (pending_words != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      $display("tb_gif_frame_compositor: %0d pixel words composed over %0d register settings,",
               word_count, setting_count);
      $display("tb_gif_frame_compositor: mid-frame width change with store aliasing, %0d mismatches",
               fail_count);
      if (fail_count == 0)
         $display("tb_gif_frame_compositor: done, clean");
      else
         $display("tb_gif_frame_compositor: done, errors");
      $finish;
   end

endmodule
